// ===== src/crat_pkg.sv =====
package crat_pkg;

  localparam int ACK_HISTORY_DEF = 64;
  localparam int ACK_COUNT_DEF   = 16;
  localparam int CHUNK_BYTES_DEF = 1024;
  localparam int NAME_LIMIT_DEF  = 128;
  localparam int TOKEN_BITS_DEF  = 32;

  localparam logic [39:0] MAX_DATA_SIZE_RST = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] ACK_INTERVAL_RST  = 32'd50;
  localparam logic [31:0] TIMEOUT_RST       = 32'd30000;

  typedef enum logic [1:0] {
    KIND_HANDSHAKE = 2'd0,
    KIND_PAYLOAD   = 2'd1,
    KIND_TICK      = 2'd2
  } in_kind_t;

  typedef enum logic [1:0] {
    RES_ACK    = 2'd0,
    RES_GRANT  = 2'd1,
    RES_REPLY  = 2'd2,
    RES_EXPIRE = 2'd3
  } res_kind_t;

  typedef enum logic [1:0] {
    CFG_MAX_DATA_SIZE = 2'd0,
    CFG_ACK_INTERVAL  = 2'd1,
    CFG_TIMEOUT       = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_FLUSH,
    ST_DECIDE,
    ST_WRITE,
    ST_BSTART,
    ST_BREAD,
    ST_BOUT,
    ST_GRANT,
    ST_REPLY,
    ST_TCHECK,
    ST_EXPIRE
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [39:0] data_size;
    logic [15:0] name_size;
    logic        length_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      load;
    logic      hs_apply;
    logic      pay_start;
    logic      search_step;
    logic      decide;
    logic      ring_write;
    logic      burst_start;
    logic      burst_sel;
    logic      burst_step;
    logic      tick_count;
    logic      ack_clear;
    logic      expire;
    logic      emit;
    res_kind_t emit_kind;
    logic      emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       hs_ok;
    logic       active;
    logic       pay_ok;
    logic       search_last;
    logic       hit;
    logic       beyond;
    logic       trigger;
    logic       got_data;
    logic       timed_out;
    logic       ack_due;
    logic       burst_last;
    logic       grant;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== src/crat_ctrl.sv =====
module crat_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  crat_pkg::dp_status_t  status,
  output crat_pkg::dp_cmd_t     cmd
);

  crat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != crat_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.emit_kind = crat_pkg::RES_ACK;
    case (state)
      crat_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = crat_pkg::ST_DECODE;
        end
      end
      crat_pkg::ST_DECODE: begin
        state_next = crat_pkg::ST_IDLE;
        case (status.kind)
          crat_pkg::KIND_HANDSHAKE: begin
            if (status.hs_ok) begin
              cmd.hs_apply = 1'b1;
              state_next = crat_pkg::ST_REPLY;
            end
          end
          crat_pkg::KIND_PAYLOAD: begin
            if (status.pay_ok) begin
              cmd.pay_start = 1'b1;
              state_next = crat_pkg::ST_SEARCH;
            end
          end
          crat_pkg::KIND_TICK: begin
            if (status.active) begin
              cmd.tick_count = 1'b1;
              state_next = crat_pkg::ST_TCHECK;
            end
          end
          default: state_next = crat_pkg::ST_IDLE;
        endcase
      end
      crat_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_last) state_next = crat_pkg::ST_FLUSH;
      end
      crat_pkg::ST_FLUSH: state_next = crat_pkg::ST_DECIDE;
      crat_pkg::ST_DECIDE: begin
        if (status.hit) begin
          state_next = crat_pkg::ST_WRITE;
        end else if (status.beyond) begin
          state_next = crat_pkg::ST_IDLE;
        end else begin
          cmd.decide = 1'b1;
          state_next = crat_pkg::ST_WRITE;
        end
      end
      crat_pkg::ST_WRITE: begin
        cmd.ring_write = 1'b1;
        if (status.trigger) state_next = crat_pkg::ST_BSTART;
        else if (status.grant) state_next = crat_pkg::ST_GRANT;
        else state_next = crat_pkg::ST_IDLE;
      end
      crat_pkg::ST_BSTART: begin
        cmd.burst_start = 1'b1;
        state_next = crat_pkg::ST_BREAD;
      end
      crat_pkg::ST_BREAD: begin
        cmd.burst_sel = 1'b1;
        state_next = crat_pkg::ST_BOUT;
      end
      crat_pkg::ST_BOUT: begin
        cmd.burst_sel = 1'b1;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = crat_pkg::RES_ACK;
          cmd.emit_last = status.burst_last && !status.grant;
          cmd.burst_step = 1'b1;
          if (!status.burst_last) state_next = crat_pkg::ST_BREAD;
          else if (status.grant) state_next = crat_pkg::ST_GRANT;
          else state_next = crat_pkg::ST_IDLE;
        end
      end
      crat_pkg::ST_GRANT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = crat_pkg::RES_GRANT;
          cmd.emit_last = 1'b1;
          state_next = crat_pkg::ST_IDLE;
        end
      end
      crat_pkg::ST_REPLY: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = crat_pkg::RES_REPLY;
          cmd.emit_last = 1'b1;
          state_next = crat_pkg::ST_IDLE;
        end
      end
      crat_pkg::ST_TCHECK: begin
        state_next = crat_pkg::ST_IDLE;
        if (status.timed_out) begin
          state_next = crat_pkg::ST_EXPIRE;
        end else if (status.ack_due) begin
          if (status.got_data) state_next = crat_pkg::ST_BSTART;
          else cmd.ack_clear = 1'b1;
        end
      end
      crat_pkg::ST_EXPIRE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.emit_kind = crat_pkg::RES_EXPIRE;
          cmd.emit_last = 1'b1;
          cmd.expire = 1'b1;
          state_next = crat_pkg::ST_IDLE;
        end
      end
      default: state_next = crat_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/crat_dp.sv =====
module crat_dp #(
  parameter int ACK_HISTORY = crat_pkg::ACK_HISTORY_DEF,
  parameter int ACK_COUNT   = crat_pkg::ACK_COUNT_DEF,
  parameter int CHUNK_BYTES = crat_pkg::CHUNK_BYTES_DEF,
  parameter int NAME_LIMIT  = crat_pkg::NAME_LIMIT_DEF,
  parameter int TOKEN_BITS  = crat_pkg::TOKEN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  crat_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output crat_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [39:0]           cfg_data,
  input  crat_pkg::dp_cmd_t     cmd,
  output crat_pkg::dp_status_t  status
);

  localparam int PW = (ACK_HISTORY > 1) ? $clog2(ACK_HISTORY) : 1;
  localparam int CW = $clog2(ACK_COUNT + 1);
  localparam int BW = $clog2(CHUNK_BYTES + 1);
  localparam int OW = 32 + BW;
  localparam int BACK = ACK_COUNT % ACK_HISTORY;
  localparam logic [PW-1:0] TRIG = PW'(BACK);
  localparam logic [PW-1:0] LAST_POS = PW'(ACK_HISTORY - 1);
  localparam logic [CW-1:0] LAST_WORD = CW'(ACK_COUNT - 1);
  localparam logic [32:0] TMASK_W = (33'd1 << TOKEN_BITS) - 33'd1;
  localparam logic [31:0] TMASK = TMASK_W[31:0];

  logic [39:0] max_data_size;
  logic [31:0] ack_interval_ticks;
  logic [31:0] timeout_ticks;

  crat_pkg::in_item_t item;
  logic active;
  logic got_data;
  logic [31:0] token;
  logic [31:0] token_count;
  logic [39:0] transfer_bytes;
  logic [31:0] since_ack;
  logic [31:0] since_recv;
  logic [PW-1:0] write_pos;
  logic [PW-1:0] gap;
  logic [PW-1:0] sidx;
  logic [PW-1:0] bpos;
  logic [CW-1:0] bidx;
  logic cmp_en;
  logic hit;
  logic grant;
  logic [OW-1:0] prod;

  logic [31:0] ring [ACK_HISTORY];
  logic [ACK_HISTORY-1:0] ring_vld;
  logic [31:0] rdata;
  logic rvld;
  logic [PW-1:0] raddr;
  logic [31:0] entry;
  logic [PW-1:0] wp_inc;
  logic [PW-1:0] gap_inc;
  logic [PW-1:0] bpos_inc;
  logic [PW:0] bstart_w;
  logic [31:0] token_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_data_size <= crat_pkg::MAX_DATA_SIZE_RST;
      ack_interval_ticks <= crat_pkg::ACK_INTERVAL_RST;
      timeout_ticks <= crat_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        crat_pkg::CFG_MAX_DATA_SIZE: max_data_size <= cfg_data;
        crat_pkg::CFG_ACK_INTERVAL:  ack_interval_ticks <= cfg_data[31:0];
        crat_pkg::CFG_TIMEOUT:       timeout_ticks <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign wp_inc   = (write_pos == LAST_POS) ? '0 : write_pos + 1'b1;
  assign gap_inc  = (gap == LAST_POS) ? '0 : gap + 1'b1;
  assign bpos_inc = (bpos == LAST_POS) ? '0 : bpos + 1'b1;
  assign bstart_w = ({1'b0, write_pos} >= (PW+1)'(BACK)) ?
                    {1'b0, write_pos} - (PW+1)'(BACK) :
                    {1'b0, write_pos} + (PW+1)'(ACK_HISTORY - BACK);
  assign token_count_next = token_count + 32'd1;

  assign raddr = cmd.burst_sel ? bpos : sidx;
  assign entry = rvld ? rdata : '1;

  always_ff @(posedge clk) begin
    if (cmd.ring_write) ring[write_pos] <= item.seq;
    rdata <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      rvld <= 1'b0;
    end else begin
      rvld <= ring_vld[raddr];
      if (cmd.hs_apply && !active) begin
        ring_vld <= '0;
      end else if (cmd.ring_write) begin
        ring_vld[write_pos] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.pay_start) prod <= OW'(item.seq) * OW'(CHUNK_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      got_data <= 1'b0;
      token <= '0;
      token_count <= '0;
      transfer_bytes <= '0;
      since_ack <= '0;
      since_recv <= '0;
      write_pos <= '0;
      gap <= '0;
      sidx <= '0;
      bpos <= '0;
      bidx <= '0;
      cmp_en <= 1'b0;
      hit <= 1'b0;
      grant <= 1'b0;
    end else begin
      cmp_en <= cmd.search_step;
      if (cmd.load) grant <= 1'b0;
      if (cmd.hs_apply) begin
        since_recv <= '0;
        if (!active) begin
          active <= 1'b1;
          token_count <= token_count_next;
          token <= token_count_next & TMASK;
          write_pos <= '0;
          gap <= '0;
          got_data <= 1'b0;
          transfer_bytes <= item.data_size;
          since_ack <= '0;
        end
      end
      if (cmd.pay_start) begin
        got_data <= 1'b1;
        since_recv <= '0;
        sidx <= '0;
        hit <= 1'b0;
      end
      if (cmd.search_step) sidx <= (sidx == LAST_POS) ? '0 : sidx + 1'b1;
      if (cmp_en && entry == item.seq) hit <= 1'b1;
      if (cmd.decide) grant <= 1'b1;
      if (cmd.ring_write) begin
        write_pos <= wp_inc;
        gap <= gap_inc;
      end
      if (cmd.burst_start) begin
        bpos <= bstart_w[PW-1:0];
        bidx <= '0;
        gap <= '0;
        since_ack <= '0;
      end
      if (cmd.burst_step) begin
        bpos <= bpos_inc;
        bidx <= bidx + 1'b1;
      end
      if (cmd.tick_count) begin
        if (since_recv != '1) since_recv <= since_recv + 32'd1;
        if (since_ack != '1) since_ack <= since_ack + 32'd1;
      end
      if (cmd.ack_clear) since_ack <= '0;
      if (cmd.expire) active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.result_kind <= cmd.emit_kind;
      out_data.last <= cmd.emit_last;
      case (cmd.emit_kind)
        crat_pkg::RES_ACK:   out_data.value <= entry;
        crat_pkg::RES_GRANT: out_data.value <= item.seq;
        default:             out_data.value <= token;
      endcase
    end
  end

  always_comb begin
    status.kind = item.kind;
    status.hs_ok = !(item.data_size > max_data_size) && (item.name_size != '0) &&
                   !(item.name_size > 16'(NAME_LIMIT));
    status.active = active;
    status.pay_ok = active && item.length_ok;
    status.search_last = (sidx == LAST_POS);
    status.hit = hit;
    status.beyond = (64'(prod) >= 64'(transfer_bytes));
    status.trigger = (gap_inc == TRIG);
    status.got_data = got_data;
    status.timed_out = (since_recv > timeout_ticks);
    status.ack_due = (since_ack > ack_interval_ticks);
    status.burst_last = (bidx == LAST_WORD);
    status.grant = grant;
    status.out_free = !out_valid || !out_stall;
  end

endmodule

// ===== src/chunk_receiver_ack_tracker.sv =====
// The payload duplicate search reads one ring entry per cycle, covering all ACK_HISTORY
// entries. An ack burst of ACK_COUNT entries can follow a payload or a tick.
// Output stalls hold the burst and the single-word results.
// Throughput: one transaction at a time; input stalls until the previous one finishes.
// Reset (rst, synchronous): control state and counters to reset values; ring data, item
// and output data are not reset; ring entries are invalidated at once, no clearing pass.
module chunk_receiver_ack_tracker #(
  parameter int ACK_HISTORY = crat_pkg::ACK_HISTORY_DEF,
  parameter int ACK_COUNT   = crat_pkg::ACK_COUNT_DEF,
  parameter int CHUNK_BYTES = crat_pkg::CHUNK_BYTES_DEF,
  parameter int NAME_LIMIT  = crat_pkg::NAME_LIMIT_DEF,
  parameter int TOKEN_BITS  = crat_pkg::TOKEN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  crat_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crat_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [39:0]          cfg_data
);

  crat_pkg::dp_cmd_t    cmd;
  crat_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  crat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  crat_dp #(
    .ACK_HISTORY (ACK_HISTORY),
    .ACK_COUNT   (ACK_COUNT),
    .CHUNK_BYTES (CHUNK_BYTES),
    .NAME_LIMIT  (NAME_LIMIT),
    .TOKEN_BITS  (TOKEN_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
